[src/itoa_pkg.sv]
// ----------------------------------------------------------------------------
// itoa_pkg: shared types and constants for the integer to ASCII converter
// Holds the word and digit sizing, character codes, mode codes, the
// controller state type and the command/status bundles.
// ----------------------------------------------------------------------------
package itoa_pkg;

  // Word size and derived digit counts
  localparam int WORD_BITS  = 32;
  localparam int DEC_DIGITS = ((WORD_BITS * 1233) >> 12) + 1;
  localparam int DIG_BITS   = 4 * DEC_DIGITS;
  localparam int CNT_W      = $clog2(WORD_BITS + 1);
  localparam int IDX_W      = (DEC_DIGITS > 1) ? $clog2(DEC_DIGITS) : 1;

  // Mode codes
  localparam logic [1:0] MODE_SDEC = 2'd0;
  localparam logic [1:0] MODE_HEX  = 2'd1;

  // Character codes
  localparam logic [6:0] CHAR_MINUS    = 7'h2d;
  localparam logic [6:0] CHAR_ZERO     = 7'h30;
  localparam logic [6:0] CHAR_LOWER_A  = 7'h61;
  localparam logic [6:0] CHAR_HEX_BASE = CHAR_LOWER_A - 7'd10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SEEK,
    ST_SIGN,
    ST_EMIT
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic step;
    logic seek;
    logic emit_sign;
    logic emit_digit;
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic negative;
    logic conv_done;
    logic last_digit;
  } dp_sts_t;

endpackage

[src/integer_to_ascii_digits.sv]
// ----------------------------------------------------------------------------
// integer_to_ascii_digits: integer to ASCII text converter
// Emits the decimal or hex text of a 32-bit value one character at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_value and in_mode and raise start; the transaction is
//   taken on a rising edge where start is high and busy is low. Mode 0 is
//   signed decimal, mode 1 lower-case hex, modes 2 and 3 unsigned decimal.
//   Output: each character appears on out_character for one cycle with
//   out_valid high, most significant first; out_last marks the final one.
//   A leading '-' precedes negative values in signed decimal mode.
//   Timing: decimal first runs the bit-serial BCD converter (one shift
//   per bit of the value, then a check that sees the count done); hex
//   loads nibbles. Then the leading digit is found and the characters
//   (up to 11) follow back to back; busy is low again in the cycle the
//   last character is shown, so the next transaction may start then.
//   The receiver cannot stall; characters are never held.
//   Reset: synchronous, active low; returns to idle and drops out_valid.
// ----------------------------------------------------------------------------
module integer_to_ascii_digits (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_value,
  input  logic [1:0]  in_mode,
  output logic        out_valid,
  output logic [6:0]  out_character,
  output logic        out_last
);
  import itoa_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  // Sequencer
  itoa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Datapath
  itoa_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_value      (in_value),
    .in_mode       (in_mode),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_character (out_character),
    .out_last      (out_last)
  );

endmodule

[src/itoa_dpath.sv]
// ----------------------------------------------------------------------------
// itoa_dpath: conversion datapath
// Latches the value, converts it to BCD by shift-and-add-3 (one bit per
// cycle) or loads hex nibbles directly, finds the leading digit and drives
// the registered character output.
// ----------------------------------------------------------------------------
module itoa_dpath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [31:0]           in_value,
  input  logic [1:0]            in_mode,
  input  itoa_pkg::ctl_cmd_t    cmd,
  output itoa_pkg::dp_sts_t     sts,
  output logic                  out_valid,
  output logic [6:0]            out_character,
  output logic                  out_last
);
  import itoa_pkg::*;

  logic [WORD_BITS-1:0] word;
  logic                 neg_in;
  logic [WORD_BITS-1:0] mag;
  logic                 hex_in;

  logic [WORD_BITS-1:0] sh_r;
  logic [DIG_BITS-1:0]  dig_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [IDX_W-1:0]     idx_r;
  logic                 neg_r;

  logic [DIG_BITS-1:0]  adj;
  logic [IDX_W-1:0]     lead_idx;
  logic [3:0]           cur_nib;
  logic [6:0]           digit_char;

  logic                 out_valid_r;
  logic [6:0]           out_char_r;
  logic                 out_last_r;

  // Decode the incoming value
  assign word   = in_value[WORD_BITS-1:0];
  assign hex_in = (in_mode == MODE_HEX);
  assign neg_in = (in_mode == MODE_SDEC) && word[WORD_BITS-1];
  assign mag    = neg_in ? (~word + 1'b1) : word;

  // Add 3 to every BCD digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      adj[i*4 +: 4] = (dig_r[i*4 +: 4] >= 4'd5) ? (dig_r[i*4 +: 4] + 4'd3)
                                                 : dig_r[i*4 +: 4];
    end
  end

  // Find the most significant nonzero digit; zero maps to the lowest digit
  always_comb begin
    lead_idx = '0;
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (dig_r[i*4 +: 4] != 4'd0) begin
        lead_idx = IDX_W'(i);
      end
    end
  end

  // Map the current digit to ASCII
  assign cur_nib    = dig_r[idx_r*4 +: 4];
  assign digit_char = (cur_nib < 4'd10) ? (CHAR_ZERO + {3'b000, cur_nib})
                                        : (CHAR_HEX_BASE + {3'b000, cur_nib});

  // Conversion registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg_r <= neg_in;
      sh_r  <= mag;
      if (hex_in) begin
        dig_r <= DIG_BITS'(word);
        cnt_r <= '0;
      end else begin
        dig_r <= '0;
        cnt_r <= CNT_W'(WORD_BITS);
      end
    end else if (cmd.step) begin
      dig_r <= {adj[DIG_BITS-2:0], sh_r[WORD_BITS-1]};
      sh_r  <= {sh_r[WORD_BITS-2:0], 1'b0};
      cnt_r <= cnt_r - 1'b1;
    end
    if (cmd.seek) begin
      idx_r <= lead_idx;
    end else if (cmd.emit_digit) begin
      idx_r <= idx_r - 1'b1;
    end
  end

  // Output strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_sign | cmd.emit_digit;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      out_char_r <= CHAR_MINUS;
      out_last_r <= 1'b0;
    end else if (cmd.emit_digit) begin
      out_char_r <= digit_char;
      out_last_r <= (idx_r == '0);
    end
  end

  assign sts.negative   = neg_r;
  assign sts.conv_done  = (cnt_r == '0);
  assign sts.last_digit = (idx_r == '0);

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

`ifndef SYNTH
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_sign |=> (out_valid && !out_last && out_character == CHAR_MINUS))
    else $error("sign character flagged wrongly");
  a_seek_after_conv: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.seek |-> (cnt_r == '0))
    else $error("leading digit search before conversion finished");
  a_step_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (cnt_r != '0))
    else $error("conversion step past the last bit");
`endif

endmodule

[src/itoa_ctrl.sv]
// ----------------------------------------------------------------------------
// itoa_ctrl: conversion sequencer
// Walks each transaction through load, bit-serial conversion (decimal
// only), leading digit search, optional sign and one digit per cycle.
// ----------------------------------------------------------------------------
module itoa_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  itoa_pkg::dp_sts_t     sts,
  output itoa_pkg::ctl_cmd_t    cmd
);
  import itoa_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CONVERT;
        end
      end
      ST_CONVERT: begin
        if (sts.conv_done) begin
          state_nxt = ST_SEEK;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_SEEK: begin
        cmd.seek  = 1'b1;
        state_nxt = sts.negative ? ST_SIGN : ST_EMIT;
      end
      ST_SIGN: begin
        cmd.emit_sign = 1'b1;
        state_nxt     = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit_digit = 1'b1;
        if (sts.last_digit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

`ifndef SYNTH
  a_start_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == ST_CONVERT))
    else $error("accepted transaction did not enter conversion");
  a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.step, cmd.seek, cmd.emit_sign, cmd.emit_digit}))
    else $error("more than one datapath command");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_digit && sts.last_digit) |=> !busy)
    else $error("still busy after last digit");
`endif

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: testbench for the integer to ASCII text converter
// Drives conversion requests (value and mode) with random gaps, predicts the
// character stream of each request in signed decimal, hex and unsigned
// decimal, and compares every emitted character and its last flag in order.
// ----------------------------------------------------------------------------
module tb_top;
  import itoa_pkg::*;

  // Modes without a name in the package: both print the unsigned pattern
  localparam logic [1:0] MODE_UDEC     = 2'd2;
  localparam logic [1:0] MODE_UDEC_ALT = 2'd3;

  localparam int RANDOM_REQS = 400;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic [31:0] value;
    logic [1:0]  mode;
  } conv_req_t;

  typedef struct {
    logic [6:0] character;
    logic       last;
  } text_char_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic [31:0] in_value = '0;
  logic [1:0]  in_mode = MODE_SDEC;
  logic        busy;
  logic        out_valid;
  logic [6:0]  out_character;
  logic        out_last;

  conv_req_t  pending_reqs[$];
  text_char_t expected_text[$];

  int error_count = 0;
  int chars_checked = 0;
  int reqs_sent = 0;
  int mode_counts[4] = '{0, 0, 0, 0};
  int gap_left = 0;
  bit burst = 1'b0;

  integer_to_ascii_digits dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_value     (in_value),
    .in_mode      (in_mode),
    .out_valid    (out_valid),
    .out_character(out_character),
    .out_last     (out_last)
  );

  always #4 clk = ~clk;

  // Append the text of one value to the expected character stream
  function automatic void predict_text(logic [31:0] value, logic [1:0] mode);
    logic [31:0] mag;
    logic [31:0] radix;
    logic [31:0] rem;
    logic [6:0]  digits[$];
    bit          neg;
    text_char_t  tc;
    neg   = (mode == MODE_SDEC) && value[31];
    mag   = neg ? (32'd0 - value) : value;
    radix = (mode == MODE_HEX) ? 32'd16 : 32'd10;
    do begin
      rem = mag % radix;
      if (rem < 10) digits.push_front(CHAR_ZERO + 7'(rem));
      else digits.push_front(CHAR_LOWER_A + 7'(rem - 10));
      mag = mag / radix;
    end while (mag != 0);
    if (neg) begin
      tc.character = CHAR_MINUS;
      tc.last      = 1'b0;
      expected_text.push_back(tc);
    end
    foreach (digits[i]) begin
      tc.character = digits[i];
      tc.last      = (i == digits.size() - 1);
      expected_text.push_back(tc);
    end
  endfunction

  function automatic void add_req(logic [31:0] value, logic [1:0] mode);
    conv_req_t r;
    r.value = value;
    r.mode  = mode;
    pending_reqs.push_back(r);
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  // Spread values over digit counts, signs and decimal boundaries
  function automatic logic [31:0] pick_value();
    logic [31:0] p;
    int k;
    p = 32'd1;
    case ($urandom_range(0, 7))
      0, 1: return $urandom;
      2:    return $urandom >> $urandom_range(0, 31);
      3:    return 32'd0 - ($urandom >> $urandom_range(0, 31));
      4:    return $urandom_range(0, 20);
      5:    return 32'd0 - $urandom_range(0, 20);
      6: begin
        k = $urandom_range(0, 9);
        repeat (k) p = p * 10;
        p = p + $urandom_range(0, 2) - 1;
        return $urandom_range(0, 1) ? (32'd0 - p) : p;
      end
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'hffff_ffff;
          default: return 32'h8000_0001;
        endcase
      end
    endcase
  endfunction

  // Reset once at the start
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Build the request list: directed corners, then random requests
  initial begin
    add_req(32'd0,          MODE_SDEC);
    add_req(32'd1,          MODE_SDEC);
    add_req(32'hffff_ffff,  MODE_SDEC);
    add_req(32'h7fff_ffff,  MODE_SDEC);
    add_req(32'h8000_0000,  MODE_SDEC);
    add_req(32'd10,         MODE_SDEC);
    add_req(32'hffff_fff6,  MODE_SDEC);
    add_req(32'd9,          MODE_SDEC);
    add_req(32'd1000000000, MODE_SDEC);
    add_req(32'd0,          MODE_HEX);
    add_req(32'hffff_ffff,  MODE_HEX);
    add_req(32'h8000_0000,  MODE_HEX);
    add_req(32'habcd_ef01,  MODE_HEX);
    add_req(32'h0000_000f,  MODE_HEX);
    add_req(32'h0000_0010,  MODE_HEX);
    add_req(32'd0,          MODE_UDEC);
    add_req(32'hffff_ffff,  MODE_UDEC);
    add_req(32'h8000_0000,  MODE_UDEC);
    add_req(32'd9,          MODE_UDEC);
    add_req(32'hffff_ffff,  MODE_UDEC_ALT);
    add_req(32'h8000_0000,  MODE_UDEC_ALT);
    add_req(32'd123,        MODE_UDEC_ALT);
    add_req(32'd0,          MODE_UDEC_ALT);
    for (int i = 0; i < RANDOM_REQS; i++) begin
      add_req(pick_value(), 2'($urandom_range(0, 3)));
    end
  end

  // Driver: present the head request, drop it once the transaction is taken
  always @(posedge clk) begin
    bit accepted;
    accepted = 1'b0;
    if (rst_n) begin
      accepted = start && !busy;
      if (accepted) begin
        predict_text(pending_reqs[0].value, pending_reqs[0].mode);
        mode_counts[pending_reqs[0].mode]++;
        reqs_sent++;
        void'(pending_reqs.pop_front());
        if ($urandom_range(0, 39) == 0) burst = !burst;
        gap_left = burst ? 0 : pick_gap();
      end
      if (start && !accepted) begin
        // hold the request until busy drops
      end else if (gap_left > 0) begin
        gap_left--;
        start    <= 1'b0;
        in_value <= $urandom;
        in_mode  <= 2'($urandom_range(0, 3));
      end else if (pending_reqs.size() > 0) begin
        start    <= 1'b1;
        in_value <= pending_reqs[0].value;
        in_mode  <= pending_reqs[0].mode;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: compare each strobed character with the oldest expectation
  always @(posedge clk) begin
    text_char_t exp_c;
    if (rst_n && out_valid) begin
      if (expected_text.size() == 0) begin
        $error("unexpected character 0x%02h last=%0b", out_character, out_last);
        error_count++;
      end else begin
        exp_c = expected_text.pop_front();
        chars_checked++;
        if (out_character !== exp_c.character) begin
          $error("character: expected 0x%02h, actual 0x%02h", exp_c.character,
                 out_character);
          error_count++;
        end
        if (out_last !== exp_c.last) begin
          $error("last: expected %0b, actual %0b", exp_c.last, out_last);
          error_count++;
        end
      end
    end
  end

  // Wait for all requests and characters, then report
  initial begin
    @(posedge rst_n);
    while (pending_reqs.size() != 0 || expected_text.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Converted %0d values: %0d signed decimal, %0d hex, %0d+%0d unsigned decimal",
             reqs_sent, mode_counts[0], mode_counts[1], mode_counts[2], mode_counts[3]);
    $display("Checked %0d characters, %0d errors", chars_checked, error_count);
    if (error_count == 0) begin
      $display("integer_to_ascii_digits: match");
    end else begin
      $display("integer_to_ascii_digits: mismatch");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2000000;
    $display("Timeout with %0d requests and %0d characters outstanding",
             pending_reqs.size(), expected_text.size());
    $display("integer_to_ascii_digits: mismatch");
    $finish;
  end

endmodule

[files.f]
src/itoa_pkg.sv
src/itoa_dpath.sv
src/itoa_ctrl.sv
src/integer_to_ascii_digits.sv
tb/tb_top.sv
